@@ hw/rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cksnd_pkg.sv @@
`default_nettype none

package cksnd_pkg;

  // protocol bytes
  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;
  localparam logic [7:0] PAD_BYTE = 8'h1a;

  // frame layout
  localparam int unsigned DATA_LEN = 128;
  localparam logic [7:0] POS_IDLE = 8'd0;
  localparam logic [7:0] POS_BLK  = 8'd1;
  localparam logic [7:0] POS_CMP  = 8'd2;
  localparam logic [7:0] POS_CSUM = 8'(3 + DATA_LEN);

  // input word kinds
  localparam logic KIND_RX    = 1'b0;
  localparam logic KIND_TX_RDY = 1'b1;

  // status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_WAIT    = 2'd0;
  localparam status_t ST_FRAME   = 2'd1;
  localparam status_t ST_EOT     = 2'd2;
  localparam status_t ST_STOPPED = 2'd3;

  typedef logic [23:0] count_t;

endpackage

`default_nettype wire

@@ hw/rtl/cksnd_ifs.sv @@
`default_nettype none

// input channel: receiver byte or transmitter-ready word
interface cksnd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic [7:0] file_byte;

  modport source (output valid, kind, rx_byte, file_byte, input ready);
  modport sink   (input valid, kind, rx_byte, file_byte, output ready);
endinterface

// result channel
interface cksnd_out_if;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               file_byte_taken;
  cksnd_pkg::status_t status;

  modport source (output valid, tx_valid, tx_byte, file_byte_taken, status, input ready);
  modport sink   (input valid, tx_valid, tx_byte, file_byte_taken, status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/xmodem_checksum_sender_top.sv @@
// Sender half of the XMODEM checksum protocol.
// in_ch carries one word per event: kind 0 is a byte from the receiver
// (rx_byte), kind 1 says the line transmitter can take the next byte and
// offers the next unsent file byte (file_byte). out_ch carries the byte to
// send together with file_byte_taken and a status code; words that cause
// nothing (receiver bytes inside a frame, transmitter-ready outside a frame,
// anything once stopped) produce no result word.
// cfg_we/cfg_wdata load the file length; write it only while idle.
// A result word is in the output register in the cycle after its input
// word is accepted. Throughput: one word per cycle, set by the single
// output register, which is refilled in the same cycle it is taken.
// When the receiver stalls, in_ch.ready drops as soon as the output register
// holds an untaken word, so the state never runs ahead of the results.
// Synchronous active-low reset returns to block one, no file bytes left,
// no frame open, and an empty output register.
`default_nettype none

`include "assert_macros.svh"

module xmodem_checksum_sender_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire cksnd_pkg::count_t  cfg_wdata,
  cksnd_in_if.sink                in_ch,
  cksnd_out_if.source             out_ch
);

  // protocol state
  logic [7:0]        block_num_r, block_num_nxt;
  logic              first_blk_r, first_blk_nxt;
  cksnd_pkg::count_t bytes_left_r, bytes_left_nxt;
  logic [7:0]        frame_pos_r, frame_pos_nxt;
  logic [7:0]        run_sum_r, run_sum_nxt;
  logic              in_frame_r, in_frame_nxt;
  logic              eot_done_r, eot_done_nxt;
  logic              halted_r, halted_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic               tx_valid_r, tx_valid_nxt;
  logic [7:0]         tx_byte_r, tx_byte_nxt;
  logic               taken_r, taken_nxt;
  cksnd_pkg::status_t status_r, status_nxt;

  logic accept;
  logic emit;
  logic [7:0] data_byte;
  logic       have_file;
  logic       out_stall;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign have_file   = (bytes_left_r != '0);
  assign data_byte   = have_file ? in_ch.file_byte : cksnd_pkg::PAD_BYTE;
  assign out_stall   = out_valid_r && !out_ch.ready;

  // next state and result for one accepted word
  always_comb begin
    block_num_nxt  = block_num_r;
    first_blk_nxt  = first_blk_r;
    bytes_left_nxt = bytes_left_r;
    frame_pos_nxt  = frame_pos_r;
    run_sum_nxt    = run_sum_r;
    in_frame_nxt   = in_frame_r;
    eot_done_nxt   = eot_done_r;
    halted_nxt     = halted_r;
    emit           = 1'b0;
    tx_valid_nxt   = 1'b0;
    tx_byte_nxt    = 8'h00;
    taken_nxt      = 1'b0;
    status_nxt     = cksnd_pkg::ST_WAIT;

    if (accept && !halted_r) begin
      if (in_ch.kind == cksnd_pkg::KIND_RX) begin
        if (!in_frame_r) begin
          emit = 1'b1;
          priority if (eot_done_r) begin
            halted_nxt = 1'b1;
            status_nxt = cksnd_pkg::ST_STOPPED;
          end else if ((in_ch.rx_byte == cksnd_pkg::NAK_BYTE && first_blk_r) ||
                       (in_ch.rx_byte == cksnd_pkg::ACK_BYTE && have_file)) begin
            in_frame_nxt  = 1'b1;
            frame_pos_nxt = cksnd_pkg::POS_BLK;
            run_sum_nxt   = 8'h00;
            tx_valid_nxt  = 1'b1;
            tx_byte_nxt   = cksnd_pkg::SOH_BYTE;
            status_nxt    = cksnd_pkg::ST_FRAME;
          end else if (in_ch.rx_byte == cksnd_pkg::ACK_BYTE) begin
            eot_done_nxt = 1'b1;
            tx_valid_nxt = 1'b1;
            tx_byte_nxt  = cksnd_pkg::EOT_BYTE;
            status_nxt   = cksnd_pkg::ST_EOT;
          end else begin
            halted_nxt = 1'b1;
            status_nxt = cksnd_pkg::ST_STOPPED;
          end
        end
      end else if (in_frame_r) begin
        emit         = 1'b1;
        tx_valid_nxt = 1'b1;
        status_nxt   = cksnd_pkg::ST_FRAME;
        priority if (frame_pos_r == cksnd_pkg::POS_BLK) begin
          frame_pos_nxt = cksnd_pkg::POS_CMP;
          tx_byte_nxt   = block_num_r;
        end else if (frame_pos_r == cksnd_pkg::POS_CMP) begin
          frame_pos_nxt = frame_pos_r + 8'd1;
          tx_byte_nxt   = ~block_num_r;
        end else if (frame_pos_r < cksnd_pkg::POS_CSUM) begin
          // data byte or padding, both go into the checksum
          frame_pos_nxt = frame_pos_r + 8'd1;
          tx_byte_nxt   = data_byte;
          taken_nxt     = have_file;
          run_sum_nxt   = run_sum_r + data_byte;
          if (have_file) begin
            bytes_left_nxt = bytes_left_r - 24'd1;
          end
        end else begin
          // checksum closes the frame
          tx_byte_nxt   = run_sum_r;
          status_nxt    = cksnd_pkg::ST_WAIT;
          in_frame_nxt  = 1'b0;
          frame_pos_nxt = cksnd_pkg::POS_IDLE;
          run_sum_nxt   = 8'h00;
          block_num_nxt = block_num_r + 8'd1;
          first_blk_nxt = 1'b0;
        end
      end
    end

    // file length write reloads the byte count
    if (cfg_we) begin
      bytes_left_nxt = cfg_wdata;
    end
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_num_r  <= 8'd1;
      first_blk_r  <= 1'b1;
      bytes_left_r <= '0;
      frame_pos_r  <= cksnd_pkg::POS_IDLE;
      run_sum_r    <= 8'h00;
      in_frame_r   <= 1'b0;
      eot_done_r   <= 1'b0;
      halted_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      block_num_r  <= block_num_nxt;
      first_blk_r  <= first_blk_nxt;
      bytes_left_r <= bytes_left_nxt;
      frame_pos_r  <= frame_pos_nxt;
      run_sum_r    <= run_sum_nxt;
      in_frame_r   <= in_frame_nxt;
      eot_done_r   <= eot_done_nxt;
      halted_r     <= halted_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      tx_valid_r <= tx_valid_nxt;
      tx_byte_r  <= tx_byte_nxt;
      taken_r    <= taken_nxt;
      status_r   <= status_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.tx_valid        = tx_valid_r;
  assign out_ch.tx_byte         = tx_byte_r;
  assign out_ch.file_byte_taken = taken_r;
  assign out_ch.status          = status_r;

  // checks
  `ASSERT_ALWAYS(a_pos_range, frame_pos_r <= cksnd_pkg::POS_CSUM, "position past checksum")
  `ASSERT_ALWAYS(a_pos_frame, in_frame_r == (frame_pos_r != cksnd_pkg::POS_IDLE), "flag off")
  `ASSERT_ALWAYS(a_eot_idle, !(eot_done_r && in_frame_r), "frame open after EOT")
  `ASSERT_NEXT(a_halt_sticky, halted_r, halted_r && !emit, "stop not held")
  `ASSERT_NEXT(a_stall_hold, out_stall, out_valid_r && $stable({tx_byte_r, status_r}), "lost")

endmodule

`default_nettype wire
